// ===== hdl/gba_pkg.sv =====
// ----------------------------------------------------------------------------
// gba_pkg: shared definitions for the group-by average accumulator
// Widths, table depth, command codes and sequencer states.
// ----------------------------------------------------------------------------
package gba_pkg;

  // Table depth and derived index widths
  localparam int MAX_GROUPS = 4;
  localparam int IDX_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int UC_W       = $clog2(MAX_GROUPS + 1);

  // Field widths
  localparam int ACTION_W = 2;
  localparam int KEY_W    = 64;
  localparam int MEAS_W   = 12;
  localparam int NUM_MEAS = 4;
  localparam int SUM_W    = 28;
  localparam int CNT_W    = 16;
  localparam int GIDX_W   = 2;
  localparam int STEP_W   = $clog2(SUM_W);
  localparam int LANE_W   = $clog2(NUM_MEAS);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Command codes carried in the action field
  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REPORT = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_LOAD,
    ST_DIV
  } state_e;

endpackage

// ===== hdl/group_by_average_accumulator.sv =====
// Timing: an add is busy while keys are searched (one key compare per cycle); clear acts
// at the accepting edge and busy stays low; a report of n groups runs them all through
// one shared restoring divider, one mean at a time, last row as busy falls.
// Empty report: one result the cycle after start; busy stays low.
// Throughput: one word at a time; results are one-cycle strobes, never stalled.
// Reset (async, active low) empties the table and clears the drop counter.
// ----------------------------------------------------------------------------
// group_by_average_accumulator
// Keyed table of up to MAX_GROUPS groups with sums, counts and a drop
// counter; reports truncated means per group in insertion order.
// ----------------------------------------------------------------------------
module group_by_average_accumulator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [gba_pkg::ACTION_W-1:0] action_i,
  input  logic [gba_pkg::KEY_W-1:0]    sample_key_i,
  input  logic [gba_pkg::MEAS_W-1:0]   sepal_length_in_i,
  input  logic [gba_pkg::MEAS_W-1:0]   sepal_width_in_i,
  input  logic [gba_pkg::MEAS_W-1:0]   petal_length_in_i,
  input  logic [gba_pkg::MEAS_W-1:0]   petal_width_in_i,
  output logic                         out_valid_o,
  output logic                         group_valid_o,
  output logic [gba_pkg::GIDX_W-1:0]   group_index_o,
  output logic [gba_pkg::KEY_W-1:0]    group_key_o,
  output logic [gba_pkg::CNT_W-1:0]    sample_count_o,
  output logic [gba_pkg::MEAS_W-1:0]   avg_sepal_length_o,
  output logic [gba_pkg::MEAS_W-1:0]   avg_sepal_width_o,
  output logic [gba_pkg::MEAS_W-1:0]   avg_petal_length_o,
  output logic [gba_pkg::MEAS_W-1:0]   avg_petal_width_o,
  output logic [gba_pkg::CNT_W-1:0]    dropped_samples_o,
  output logic                         last_result_o
);
  import gba_pkg::*;

  // Group table (no reset: entries are written when a group opens)
  logic [KEY_W-1:0] keys_q [MAX_GROUPS];
  logic [SUM_W-1:0] sums_q [MAX_GROUPS][NUM_MEAS];
  logic [CNT_W-1:0] cnts_q [MAX_GROUPS];

  // Control state
  state_e          state_q, state_d;
  logic [UC_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] drop_q, drop_d;
  logic            out_valid_q, out_valid_d;

  // Working registers
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [LANE_W-1:0] lane_q, lane_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [MEAS_W-1:0] meas_q [NUM_MEAS];
  logic [MEAS_W-1:0] meas_d [NUM_MEAS];
  logic [SUM_W-1:0]  dvd_q, dvd_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [MEAS_W-1:0] avg_q [NUM_MEAS];
  logic [MEAS_W-1:0] avg_d [NUM_MEAS];

  // Result word
  logic              res_gv_q, res_gv_d;
  logic [GIDX_W-1:0] res_idx_q, res_idx_d;
  logic [KEY_W-1:0]  res_key_q, res_key_d;
  logic [CNT_W-1:0]  res_cnt_q, res_cnt_d;
  logic [CNT_W-1:0]  res_drop_q, res_drop_d;
  logic              res_last_q, res_last_d;

  // Table write port
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_idx;
  logic [KEY_W-1:0] tbl_key;
  logic [SUM_W-1:0] tbl_sum [NUM_MEAS];
  logic [CNT_W-1:0] tbl_cnt;

  // Shared datapath signals
  logic             at_end;
  logic             key_hit;
  logic [CNT_W:0]   shifted;
  logic [CNT_W:0]   trial;
  logic [SUM_W-1:0] quot;
  logic [CNT_W-1:0] cur_cnt;

  assign cur_cnt = cnts_q[idx_q];
  assign at_end  = (used_q == '0) || ((UC_W'(idx_q) + UC_W'(1)) == used_q);
  assign key_hit = (used_q != '0) && (keys_q[idx_q] == key_q);

  // Restoring divider step, one quotient bit per cycle
  assign shifted = {rem_q, dvd_q[SUM_W-1]};
  assign trial   = shifted - {1'b0, cur_cnt};
  assign quot    = {dvd_q[SUM_W-2:0], ~trial[CNT_W]};

  // Sequencer: next state, datapath updates and result word
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    drop_d      = drop_q;
    out_valid_d = 1'b0;
    idx_d       = idx_q;
    lane_d      = lane_q;
    step_d      = step_q;
    key_d       = key_q;
    meas_d      = meas_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    avg_d       = avg_q;
    res_gv_d    = res_gv_q;
    res_idx_d   = res_idx_q;
    res_key_d   = res_key_q;
    res_cnt_d   = res_cnt_q;
    res_drop_d  = res_drop_q;
    res_last_d  = res_last_q;
    tbl_we      = 1'b0;
    tbl_idx     = idx_q;
    tbl_key     = key_q;
    tbl_cnt     = cur_cnt + CNT_W'(1);
    for (int l = 0; l < NUM_MEAS; l++) begin
      tbl_sum[l] = sums_q[idx_q][l] + SUM_W'(meas_q[l]);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (action_e'(action_i))
            ACT_ADD: begin
              key_d     = sample_key_i;
              meas_d[0] = sepal_length_in_i;
              meas_d[1] = sepal_width_in_i;
              meas_d[2] = petal_length_in_i;
              meas_d[3] = petal_width_in_i;
              idx_d     = '0;
              state_d   = ST_SEARCH;
            end
            ACT_REPORT: begin
              idx_d  = '0;
              lane_d = '0;
              if (used_q == '0) begin
                // Empty table: one invalid result, straight away
                out_valid_d = 1'b1;
                res_gv_d    = 1'b0;
                res_idx_d   = '0;
                res_key_d   = '0;
                res_cnt_d   = '0;
                res_drop_d  = drop_q;
                res_last_d  = 1'b1;
                for (int l = 0; l < NUM_MEAS; l++) begin
                  avg_d[l] = '0;
                end
              end else begin
                state_d = ST_LOAD;
              end
            end
            ACT_CLEAR: begin
              used_d = '0;
              drop_d = '0;
            end
            default: ;
          endcase
        end
      end

      // One key compared per cycle
      ST_SEARCH: begin
        if (key_hit) begin
          state_d = ST_IDLE;
          if (cur_cnt == CNT_MAX) begin
            if (drop_q != CNT_MAX) drop_d = drop_q + CNT_W'(1);
          end else begin
            tbl_we = 1'b1;
          end
        end else if (at_end) begin
          state_d = ST_IDLE;
          if (used_q == UC_W'(MAX_GROUPS)) begin
            if (drop_q != CNT_MAX) drop_d = drop_q + CNT_W'(1);
          end else begin
            // Open a new group in the next free slot
            tbl_we  = 1'b1;
            tbl_idx = IDX_W'(used_q);
            tbl_cnt = CNT_W'(1);
            for (int l = 0; l < NUM_MEAS; l++) begin
              tbl_sum[l] = SUM_W'(meas_q[l]);
            end
            used_d = used_q + UC_W'(1);
          end
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      // Load one sum into the divider
      ST_LOAD: begin
        dvd_d   = sums_q[idx_q][lane_q];
        rem_d   = '0;
        step_d  = '0;
        state_d = ST_DIV;
      end

      ST_DIV: begin
        dvd_d  = quot;
        rem_d  = trial[CNT_W] ? shifted[CNT_W-1:0] : trial[CNT_W-1:0];
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(SUM_W - 1)) begin
          avg_d[lane_q] = quot[MEAS_W-1:0];
          state_d       = ST_LOAD;
          if (lane_q == LANE_W'(NUM_MEAS - 1)) begin
            // All four means done: emit this group
            out_valid_d = 1'b1;
            res_gv_d    = 1'b1;
            res_idx_d   = GIDX_W'(idx_q);
            res_key_d   = keys_q[idx_q];
            res_cnt_d   = cur_cnt;
            res_drop_d  = drop_q;
            res_last_d  = at_end;
            lane_d      = '0;
            if (at_end) begin
              state_d = ST_IDLE;
            end else begin
              idx_d = idx_q + IDX_W'(1);
            end
          end else begin
            lane_d = lane_q + LANE_W'(1);
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      drop_q      <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      lane_q      <= '0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      lane_q      <= lane_d;
      step_q      <= step_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    meas_q     <= meas_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    avg_q      <= avg_d;
    res_gv_q   <= res_gv_d;
    res_idx_q  <= res_idx_d;
    res_key_q  <= res_key_d;
    res_cnt_q  <= res_cnt_d;
    res_drop_q <= res_drop_d;
    res_last_q <= res_last_d;
  end

  // Group table write
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      keys_q[tbl_idx] <= tbl_key;
      cnts_q[tbl_idx] <= tbl_cnt;
      for (int l = 0; l < NUM_MEAS; l++) begin
        sums_q[tbl_idx][l] <= tbl_sum[l];
      end
    end
  end

  // Outputs
  assign busy               = (state_q != ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign group_valid_o      = res_gv_q;
  assign group_index_o      = res_idx_q;
  assign group_key_o        = res_key_q;
  assign sample_count_o     = res_cnt_q;
  assign avg_sepal_length_o = avg_q[0];
  assign avg_sepal_width_o  = avg_q[1];
  assign avg_petal_length_o = avg_q[2];
  assign avg_petal_width_o  = avg_q[3];
  assign dropped_samples_o  = res_drop_q;
  assign last_result_o      = res_last_q;

`ifndef ASSERT_OFF
  // More results of a report to come: the sequencer must still be running
  a_more_results_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_result_o |-> busy)
    else $error("non-final result while idle");

  // The invalid result only ever closes a report
  a_invalid_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !group_valid_o |-> last_result_o)
    else $error("invalid result not marked last");

  // Table fill never passes its depth
  a_used_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UC_W'(MAX_GROUPS))
    else $error("group count beyond table depth");
`endif

endmodule
